// ===== design/long_press_detector_macros.svh =====
// Assertion macros for the long-press detector.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LONG_PRESS_DETECTOR_MACROS_SVH
`define LONG_PRESS_DETECTOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LPD_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("long_press_detector: check failed");
// next-cycle implication
`define LPD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("long_press_detector: check failed");
`else
`define LPD_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define LPD_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== design/lpd_pkg.sv =====
// Shared constants, codes and controller/datapath link types of the long-press detector.
// No dependencies.
package lpd_pkg;

  // table size and derived widths
  localparam int MAX_FINGERS = 8;
  localparam int IDX_W       = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
  localparam int CNT_W       = $clog2(MAX_FINGERS + 1);

  // field widths
  localparam int CMD_W      = 3;
  localparam int ID_W       = 8;
  localparam int POS_W      = 16;
  localparam int STAT_W     = 2;
  localparam int FC_W       = 4;
  localparam int THR_W      = 16;
  localparam int TMO_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // arithmetic widths
  localparam int CMP_W  = (CNT_W > FC_W) ? CNT_W : FC_W;
  localparam int SUM_W  = POS_W + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * DIFF_W - 1;
  localparam int D2_W   = SQ_W + 1;

  // register reset values
  localparam logic [FC_W-1:0]  FC_RESET  = FC_W'(1);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);
  localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(500);

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGAN     = 3'd0,
    CMD_MOVED     = 3'd1,
    CMD_ENDED     = 3'd2,
    CMD_CANCELLED = 3'd3,
    CMD_TICK      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    PH_POSSIBLE   = 2'd0,
    PH_RECOGNIZED = 2'd1,
    PH_FAILED     = 2'd2
  } phase_t;

  typedef enum logic [STAT_W-1:0] {
    ST_RELEASED   = 2'd0,
    ST_RECOGNIZED = 2'd1,
    ST_FAILED     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FINGER_COUNT   = 2'd0,
    CFG_MOVE_THRESHOLD = 2'd1,
    CFG_TIMEOUT_TICKS  = 2'd2
  } cfg_reg_t;

  // operand select of the shared squarer
  typedef enum logic [1:0] {
    MOP_DX  = 2'd0,
    MOP_DY  = 2'd1,
    MOP_THR = 2'd2
  } mul_op_t;

  // controller -> datapath commands
  typedef struct packed {
    logic    load_item;
    logic    arm;
    logic    store;
    logic    set_fail;
    logic    set_recog;
    logic    set_possible;
    logic    remove;
    logic    timer_dec;
    logic    timer_stop;
    logic    pick_slot;
    logic    mul_en;
    mul_op_t mul_op;
    logic    sum_start;
    logic    sum_step;
    logic    div_start;
    logic    div_step;
    logic    out_load;
    status_t out_status;
    logic    out_rej;
    logic    out_loc;
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic found;
    logic cnt_zero;
    logic lt_fc;
    logic rem_zero;
    logic rem_lt_fc;
    logic cnt_eq_fc;
    logic ph_possible;
    logic ph_recog;
    logic armed;
    logic timer_gt1;
    logic far;
    logic sum_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/lpd_in_if.sv =====
// Touch/tick event channel of the long-press detector.
// Depends on lpd_pkg.
interface lpd_in_if;
  logic                                valid;
  logic                                ready;
  logic        [lpd_pkg::CMD_W-1:0]    command;
  logic        [lpd_pkg::ID_W-1:0]     touch_id;
  logic signed [lpd_pkg::POS_W-1:0]    pos_x;
  logic signed [lpd_pkg::POS_W-1:0]    pos_y;

  modport source (output valid, command, touch_id, pos_x, pos_y, input ready);
  modport sink   (input valid, command, touch_id, pos_x, pos_y, output ready);
endinterface

// ===== design/lpd_out_if.sv =====
// Gesture result channel of the long-press detector.
// Depends on lpd_pkg.
interface lpd_out_if;
  logic                                valid;
  logic                                ready;
  logic        [lpd_pkg::STAT_W-1:0]   status;
  logic signed [lpd_pkg::POS_W-1:0]    loc_x;
  logic signed [lpd_pkg::POS_W-1:0]    loc_y;
  logic                                touch_rejected;

  modport source (output valid, status, loc_x, loc_y, touch_rejected, input ready);
  modport sink   (input valid, status, loc_x, loc_y, touch_rejected, output ready);
endinterface

// ===== design/lpd_cfg_if.sv =====
// Register write channel of the long-press detector.
// Depends on lpd_pkg.
interface lpd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lpd_pkg::CFG_IDX_W-1:0]      index;
  logic [lpd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/lpd_div.sv =====
// Restoring divider, one quotient bit per step, for the centroid.
// Depends on lpd_pkg.
module lpd_div (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic [lpd_pkg::SUM_W-1:0]     dividend,
  input  logic [lpd_pkg::CNT_W-1:0]     divisor,
  output logic [lpd_pkg::SUM_W-1:0]     quotient
);

  logic [lpd_pkg::CNT_W-1:0] rem_r,  rem_nxt;
  logic [lpd_pkg::SUM_W-1:0] quo_r,  quo_nxt;
  logic [lpd_pkg::CNT_W:0]   rem_sh;
  logic [lpd_pkg::CNT_W:0]   rem_diff;
  logic                      q_bit;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh   = {rem_r, quo_r[lpd_pkg::SUM_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    q_bit    = (rem_sh >= {1'b0, divisor});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
    end else if (step) begin
      rem_nxt = q_bit ? rem_diff[lpd_pkg::CNT_W-1:0] : rem_sh[lpd_pkg::CNT_W-1:0];
      quo_nxt = {quo_r[lpd_pkg::SUM_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;

endmodule

// ===== design/lpd_dp.sv =====
// Datapath of the long-press detector: touch table, phase, timer, squarer,
// centroid accumulator and dividers, config registers, result register.
// Depends on lpd_pkg and lpd_div.
module lpd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lpd_pkg::ctl_t                       ctl,
  output lpd_pkg::sts_t                       sts,
  // event payload
  input  logic        [lpd_pkg::CMD_W-1:0]    in_command,
  input  logic        [lpd_pkg::ID_W-1:0]     in_touch_id,
  input  logic signed [lpd_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [lpd_pkg::POS_W-1:0]    in_pos_y,
  // register writes
  input  logic                                cfg_we,
  input  logic        [lpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [lpd_pkg::CFG_DATA_W-1:0] cfg_data,
  // result
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [lpd_pkg::STAT_W-1:0]   out_status,
  output logic signed [lpd_pkg::POS_W-1:0]    out_loc_x,
  output logic signed [lpd_pkg::POS_W-1:0]    out_loc_y,
  output logic                                out_touch_rejected
);

  localparam int NF = lpd_pkg::MAX_FINGERS;

  // configuration
  logic [lpd_pkg::FC_W-1:0]  fc_r;
  logic [lpd_pkg::THR_W-1:0] thr_r;
  logic [lpd_pkg::TMO_W-1:0] tmo_r;

  // latched event
  logic        [lpd_pkg::CMD_W-1:0] item_cmd_r;
  logic        [lpd_pkg::ID_W-1:0]  item_id_r;
  logic signed [lpd_pkg::POS_W-1:0] item_x_r;
  logic signed [lpd_pkg::POS_W-1:0] item_y_r;

  // touch table
  logic        [NF-1:0]                        used_r, used_nxt;
  logic        [NF-1:0][lpd_pkg::ID_W-1:0]     touch_r;
  logic signed [NF-1:0][lpd_pkg::POS_W-1:0]    start_x_r;
  logic signed [NF-1:0][lpd_pkg::POS_W-1:0]    start_y_r;

  // gesture state
  lpd_pkg::phase_t            phase_r, phase_nxt;
  logic [lpd_pkg::TMO_W-1:0]  timer_r, timer_nxt;
  logic                       armed_r, armed_nxt;

  // table lookups
  logic                       found;
  logic [lpd_pkg::IDX_W-1:0]  match_idx;
  logic [lpd_pkg::IDX_W-1:0]  free_idx;
  logic [lpd_pkg::CNT_W-1:0]  held;
  logic [lpd_pkg::CNT_W-1:0]  rem;
  logic [lpd_pkg::CMP_W-1:0]  fc_c;

  // shared read port
  logic        [lpd_pkg::IDX_W-1:0] rd_idx_r;
  logic signed [lpd_pkg::POS_W-1:0] rd_x;
  logic signed [lpd_pkg::POS_W-1:0] rd_y;
  logic                             rd_used;

  // move check
  logic signed [lpd_pkg::DIFF_W-1:0]   dx, dy, mul_a;
  logic signed [2*lpd_pkg::DIFF_W-1:0] prod_full;
  logic        [lpd_pkg::SQ_W-1:0]     prod_r;
  logic        [lpd_pkg::D2_W-1:0]     d2_r;

  // centroid
  logic signed [lpd_pkg::SUM_W-1:0]  sum_x_r, sum_y_r;
  logic        [lpd_pkg::SUM_W-1:0]  mag_x, mag_y, quo_x, quo_y;
  logic        [lpd_pkg::DCNT_W-1:0] div_cnt_r;
  logic        [lpd_pkg::POS_W-1:0]  qx_lo, qy_lo;
  logic signed [lpd_pkg::POS_W-1:0]  cx, cy;

  // result register
  logic                              out_valid_r;
  lpd_pkg::status_t                  out_status_r;
  logic signed [lpd_pkg::POS_W-1:0]  out_x_r, out_y_r;
  logic                              out_rej_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r  <= lpd_pkg::FC_RESET;
      thr_r <= lpd_pkg::THR_RESET;
      tmo_r <= lpd_pkg::TMO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpd_pkg::CFG_FINGER_COUNT:   fc_r  <= cfg_data[lpd_pkg::FC_W-1:0];
        lpd_pkg::CFG_MOVE_THRESHOLD: thr_r <= cfg_data[lpd_pkg::THR_W-1:0];
        lpd_pkg::CFG_TIMEOUT_TICKS:  tmo_r <= cfg_data[lpd_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // event latch
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_cmd_r <= in_command;
      item_id_r  <= in_touch_id;
      item_x_r   <= in_pos_x;
      item_y_r   <= in_pos_y;
    end
  end

  // id match, first free slot, held count (lowest index wins)
  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    held      = '0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (used_r[i] && (touch_r[i] == item_id_r)) begin
        found     = 1'b1;
        match_idx = lpd_pkg::IDX_W'(i);
      end
      if (!used_r[i]) begin
        free_idx = lpd_pkg::IDX_W'(i);
      end
    end
    for (int i = 0; i < NF; i++) begin
      held = held + lpd_pkg::CNT_W'(used_r[i]);
    end
  end

  assign rem  = held - lpd_pkg::CNT_W'(found);
  assign fc_c = lpd_pkg::CMP_W'(fc_r);

  // table update
  always_comb begin
    used_nxt = used_r;
    if (ctl.arm) begin
      used_nxt = '0;
    end
    if (ctl.store) begin
      used_nxt[free_idx] = 1'b1;
    end
    if (ctl.remove) begin
      used_nxt[match_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.store) begin
      touch_r[free_idx]   <= item_id_r;
      start_x_r[free_idx] <= item_x_r;
      start_y_r[free_idx] <= item_y_r;
    end
  end

  // phase and timer; fail outranks the other phase moves
  always_comb begin
    phase_nxt = phase_r;
    if (ctl.set_fail) begin
      phase_nxt = lpd_pkg::PH_FAILED;
    end else if (ctl.set_recog) begin
      phase_nxt = lpd_pkg::PH_RECOGNIZED;
    end else if (ctl.set_possible || ctl.arm) begin
      phase_nxt = lpd_pkg::PH_POSSIBLE;
    end
    timer_nxt = timer_r;
    armed_nxt = armed_r;
    if (ctl.arm) begin
      timer_nxt = tmo_r;
      armed_nxt = 1'b1;
    end else if (ctl.timer_dec) begin
      timer_nxt = timer_r - lpd_pkg::TMO_W'(1);
    end else if (ctl.timer_stop) begin
      timer_nxt = '0;
      armed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpd_pkg::PH_POSSIBLE;
      timer_r <= '0;
      armed_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      armed_r <= armed_nxt;
    end
  end

  // read index: matched slot for a move, sweep counter for the centroid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (ctl.pick_slot) begin
      rd_idx_r <= match_idx;
    end else if (ctl.sum_start) begin
      rd_idx_r <= '0;
    end else if (ctl.sum_step) begin
      rd_idx_r <= rd_idx_r + lpd_pkg::IDX_W'(1);
    end
  end

  assign rd_x    = start_x_r[rd_idx_r];
  assign rd_y    = start_y_r[rd_idx_r];
  assign rd_used = used_r[rd_idx_r];

  // squared distance against squared threshold, one square per cycle
  assign dx = lpd_pkg::DIFF_W'(item_x_r) - lpd_pkg::DIFF_W'(rd_x);
  assign dy = lpd_pkg::DIFF_W'(item_y_r) - lpd_pkg::DIFF_W'(rd_y);

  always_comb begin
    case (ctl.mul_op)
      lpd_pkg::MOP_DX: mul_a = dx;
      lpd_pkg::MOP_DY: mul_a = dy;
      default:         mul_a = lpd_pkg::DIFF_W'($signed({1'b0, thr_r}));
    endcase
  end

  assign prod_full = mul_a * mul_a;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_full[lpd_pkg::SQ_W-1:0];
      case (ctl.mul_op)
        lpd_pkg::MOP_DY:  d2_r <= lpd_pkg::D2_W'(prod_r);
        lpd_pkg::MOP_THR: d2_r <= d2_r + lpd_pkg::D2_W'(prod_r);
        default: ;
      endcase
    end
  end

  // centroid sums, one slot per cycle
  always_ff @(posedge clk) begin
    if (ctl.sum_start) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else if (ctl.sum_step && rd_used) begin
      sum_x_r <= sum_x_r + lpd_pkg::SUM_W'(rd_x);
      sum_y_r <= sum_y_r + lpd_pkg::SUM_W'(rd_y);
    end
  end

  // magnitudes into the dividers, sign restored at the result
  assign mag_x = sum_x_r[lpd_pkg::SUM_W-1] ? -sum_x_r : sum_x_r;
  assign mag_y = sum_y_r[lpd_pkg::SUM_W-1] ? -sum_y_r : sum_y_r;

  lpd_div u_div_x (
    .clk      (clk),
    .start    (ctl.div_start),
    .step     (ctl.div_step),
    .dividend (mag_x),
    .divisor  (held),
    .quotient (quo_x)
  );

  lpd_div u_div_y (
    .clk      (clk),
    .start    (ctl.div_start),
    .step     (ctl.div_step),
    .dividend (mag_y),
    .divisor  (held),
    .quotient (quo_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (ctl.div_start) begin
      div_cnt_r <= lpd_pkg::DCNT_W'(lpd_pkg::SUM_W - 1);
    end else if (ctl.div_step) begin
      div_cnt_r <= div_cnt_r - lpd_pkg::DCNT_W'(1);
    end
  end

  assign qx_lo = quo_x[lpd_pkg::POS_W-1:0];
  assign qy_lo = quo_y[lpd_pkg::POS_W-1:0];
  assign cx    = sum_x_r[lpd_pkg::SUM_W-1] ? -qx_lo : qx_lo;
  assign cy    = sum_y_r[lpd_pkg::SUM_W-1] ? -qy_lo : qy_lo;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status_r <= ctl.out_status;
      out_rej_r    <= ctl.out_rej;
      // no touches held: centroid reads as zero
      if (ctl.out_loc && (held != '0)) begin
        out_x_r <= cx;
        out_y_r <= cy;
      end else begin
        out_x_r <= '0;
        out_y_r <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_loc_x          = out_x_r;
  assign out_loc_y          = out_y_r;
  assign out_touch_rejected = out_rej_r;

  // status to the controller
  always_comb begin
    sts.cmd         = item_cmd_r;
    sts.found       = found;
    sts.cnt_zero    = (held == '0);
    sts.lt_fc       = (lpd_pkg::CMP_W'(held) < fc_c) &&
                      (held < lpd_pkg::CNT_W'(lpd_pkg::MAX_FINGERS));
    sts.rem_zero    = (rem == '0);
    sts.rem_lt_fc   = (lpd_pkg::CMP_W'(rem) < fc_c);
    sts.cnt_eq_fc   = (lpd_pkg::CMP_W'(held) == fc_c);
    sts.ph_possible = (phase_r == lpd_pkg::PH_POSSIBLE);
    sts.ph_recog    = (phase_r == lpd_pkg::PH_RECOGNIZED);
    sts.armed       = armed_r;
    sts.timer_gt1   = (timer_r > lpd_pkg::TMO_W'(1));
    sts.far         = (d2_r >= lpd_pkg::D2_W'(prod_r));
    sts.sum_last    = (rd_idx_r == lpd_pkg::IDX_W'(lpd_pkg::MAX_FINGERS - 1));
    sts.div_last    = (div_cnt_r == '0);
    sts.out_free    = !out_valid_r || out_ready;
  end

endmodule

// ===== design/lpd_ctrl.sv =====
// Controller of the long-press detector: sequences event decode, the move
// check, the centroid sweep and division, and result hand-off.
// Depends on lpd_pkg.
module lpd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lpd_pkg::sts_t sts,
  output lpd_pkg::ctl_t ctl
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_EXEC  = 10'b00_0000_0010,
    S_SQX   = 10'b00_0000_0100,
    S_SQY   = 10'b00_0000_1000,
    S_SQT   = 10'b00_0001_0000,
    S_CMP   = 10'b00_0010_0000,
    S_SUM   = 10'b00_0100_0000,
    S_DIVLD = 10'b00_1000_0000,
    S_DIV   = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  lpd_pkg::status_t res_status_r, res_status_nxt;
  logic             res_rej_r, res_rej_nxt;
  logic             res_loc_r, res_loc_nxt;

  always_comb begin
    ctl            = '0;
    in_ready       = 1'b0;
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_rej_nxt    = res_rej_r;
    res_loc_nxt    = res_loc_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end

      // decode of the latched event
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (sts.cmd) inside
          lpd_pkg::CMD_BEGAN: begin
            ctl.arm = sts.cnt_zero;
            if (sts.lt_fc) begin
              ctl.store = !sts.found;
            end else begin
              ctl.set_fail   = 1'b1;
              res_status_nxt = lpd_pkg::ST_FAILED;
              res_rej_nxt    = 1'b1;
              res_loc_nxt    = 1'b0;
              state_nxt      = S_EMIT;
            end
          end
          lpd_pkg::CMD_MOVED: begin
            if (sts.ph_possible && sts.found) begin
              ctl.pick_slot = 1'b1;
              state_nxt     = S_SQX;
            end
          end
          lpd_pkg::CMD_ENDED, lpd_pkg::CMD_CANCELLED: begin
            ctl.remove = sts.found;
            if (sts.cmd == lpd_pkg::CMD_CANCELLED) begin
              ctl.set_fail = 1'b1;
            end
            if ((sts.cmd == lpd_pkg::CMD_ENDED) && sts.ph_recog && sts.rem_zero) begin
              ctl.set_possible = 1'b1;
              res_status_nxt   = lpd_pkg::ST_RELEASED;
              res_rej_nxt      = 1'b0;
              res_loc_nxt      = 1'b0;
              state_nxt        = S_EMIT;
            end else if (sts.rem_lt_fc) begin
              ctl.set_fail   = 1'b1;
              res_status_nxt = lpd_pkg::ST_FAILED;
              res_rej_nxt    = 1'b0;
              res_loc_nxt    = 1'b0;
              state_nxt      = S_EMIT;
            end
          end
          lpd_pkg::CMD_TICK: begin
            if (sts.armed) begin
              if (sts.timer_gt1) begin
                ctl.timer_dec = 1'b1;
              end else begin
                ctl.timer_stop = 1'b1;
                if (sts.ph_possible && sts.cnt_eq_fc) begin
                  ctl.sum_start = 1'b1;
                  state_nxt     = S_SUM;
                end
              end
            end
          end
          default: ;
        endcase
      end

      // squarer: dx^2, dy^2, threshold^2, then compare
      S_SQX: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = lpd_pkg::MOP_DX;
        state_nxt  = S_SQY;
      end
      S_SQY: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = lpd_pkg::MOP_DY;
        state_nxt  = S_SQT;
      end
      S_SQT: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = lpd_pkg::MOP_THR;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        ctl.set_fail = sts.far;
        state_nxt    = S_IDLE;
      end

      // centroid sweep over all slots
      S_SUM: begin
        ctl.sum_step = 1'b1;
        if (sts.sum_last) begin
          state_nxt = S_DIVLD;
        end
      end
      S_DIVLD: begin
        ctl.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          ctl.set_recog  = 1'b1;
          res_status_nxt = lpd_pkg::ST_RECOGNIZED;
          res_rej_nxt    = 1'b0;
          res_loc_nxt    = 1'b1;
          state_nxt      = S_EMIT;
        end
      end

      // wait for the result register to drain
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    ctl.out_status = res_status_r;
    ctl.out_rej    = res_rej_r;
    ctl.out_loc    = res_loc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_status_r <= lpd_pkg::ST_RELEASED;
      res_rej_r    <= 1'b0;
      res_loc_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      res_rej_r    <= res_rej_nxt;
      res_loc_r    <= res_loc_nxt;
    end
  end

endmodule

// ===== design/long_press_detector.sv =====
// Long-press gesture detector, top level: controller plus datapath.
// Depends on lpd_pkg, lpd_in_if, lpd_out_if, lpd_cfg_if, lpd_ctrl, lpd_dp and the macro header.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  in_ch    | in  | valid / ready | command, touch_id, pos_x, pos_y
//  out_ch   | out | valid / ready | status, loc_x, loc_y, touch_rejected
//  cfg_ch   | in  | valid / ready | index, data (ready always high)
//
// One event at a time; an event that produces a result also passes through the emit state.
// A move makes three passes through one 17x17 squarer; a recognizing tick runs the
// slot-by-slot centroid sweep, then the one-bit-per-cycle dividers.
// Synchronous reset, no clearing pass. A result waits in the output register while
// the next event is taken; a second result stalls until the first is accepted.
`include "long_press_detector_macros.svh"

module long_press_detector (
  input  logic        clk,
  input  logic        rst_n,
  lpd_in_if.sink      in_ch,
  lpd_out_if.source   out_ch,
  lpd_cfg_if.sink     cfg_ch
);

  lpd_pkg::ctl_t ctl;
  lpd_pkg::sts_t sts;
  logic          cfg_we;
  logic          res_not_recog;
  logic          res_loc_zero;

  // registers always writable
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  lpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lpd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_command         (in_ch.command),
    .in_touch_id        (in_ch.touch_id),
    .in_pos_x           (in_ch.pos_x),
    .in_pos_y           (in_ch.pos_y),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_loc_x          (out_ch.loc_x),
    .out_loc_y          (out_ch.loc_y),
    .out_touch_rejected (out_ch.touch_rejected)
  );

  // terms for the centroid check
  assign res_not_recog = out_ch.valid && (out_ch.status != lpd_pkg::ST_RECOGNIZED);
  assign res_loc_zero  = (out_ch.loc_x == '0) && (out_ch.loc_y == '0);

  // checks
  `LPD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `LPD_ASSERT_IMPL(a_no_result_overwrite, clk, rst_n, ctl.out_load, !out_ch.valid || out_ch.ready)
  `LPD_ASSERT_IMPL(a_store_new_id_only, clk, rst_n, ctl.store, !sts.found && sts.lt_fc)
  `LPD_ASSERT_IMPL(a_loc_only_on_recog, clk, rst_n, res_not_recog, res_loc_zero)

endmodule
